>>> rtl/ftsr_pkg.sv
// ----------------------------------------------------------------------------
// ftsr_pkg
// Shared types, widths and constants of the fan tach speed regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ftsr_pkg;

  // channel field widths
  localparam int CMD_W      = 2;
  localparam int TACH_W     = 4;
  localparam int SLOT_W     = 3;
  localparam int FIDX_W     = 2;
  localparam int RPM_BITS   = 16;
  localparam int DUTY_W     = 8;
  localparam int SPEED_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // fans with their own output fields and config bytes
  localparam int OUT_FANS = 4;
  localparam int MAX_FANS = 8;

  // config reset values
  localparam logic [7:0]  DUTY_STEP_RST      = 8'd1;
  localparam logic [31:0] INITIAL_DUTIES_RST = 32'h8080_8080;
  localparam logic [7:0]  FAN_MODES_RST      = 8'h59;
  localparam logic [31:0] FIXED_DUTIES_RST   = 32'h0000_0000;
  localparam logic [RPM_BITS-1:0] TARGET_RST [OUT_FANS] = '{
    16'd1395, 16'd500, 16'd600, 16'd600
  };

  // fan modes
  localparam logic [1:0] MODE_STATIC  = 2'd0;
  localparam logic [1:0] MODE_DYNAMIC = 2'd1;

  // regulation constants
  localparam int DEADBAND    = 15;
  localparam int ERR_SAT_LIM = 1600;  // err / 100 reaches 16 here
  localparam int DIV100_MUL  = 5243;  // x / 100 == (x * 5243) >> 19 for x < 43699
  localparam int DIV100_SH   = 19;
  localparam int DUTY_MAX    = 255;

  // tick phase just before the regulating tick
  localparam logic [1:0] PHASE_PRE_REG = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TACH       = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_SET_TARGET = 2'd2,
    CMD_RESTORE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_STEP      = 3'd0,
    REG_INITIAL_DUTIES = 3'd1,
    REG_FAN_MODES      = 3'd2,
    REG_FIXED_DUTIES   = 3'd3,
    REG_TARGET_FAN0    = 3'd4,
    REG_TARGET_FAN1    = 3'd5,
    REG_TARGET_FAN2    = 3'd6,
    REG_TARGET_FAN3    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ERR,
    ST_DIV,
    ST_SQR,
    ST_STEP,
    ST_APPLY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic fan_clr;
    logic err_en;
    logic div_en;
    logic sqr_en;
    logic step_en;
    logic apply_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic regulate;
    logic last_fan;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/ftsr_in_if.sv
// ----------------------------------------------------------------------------
// ftsr_in_if
// Request channel of the regulator: command and its operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftsr_in_if
  import ftsr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TACH_W-1:0]   tach_bits;
  logic [SLOT_W-1:0]   sample_slot;
  logic [FIDX_W-1:0]   fan_index;
  logic [RPM_BITS-1:0] target_value;

  modport source (
    output valid, command, tach_bits, sample_slot, fan_index, target_value,
    input  ready
  );

  modport sink (
    input  valid, command, tach_bits, sample_slot, fan_index, target_value,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/ftsr_out_if.sv
// ----------------------------------------------------------------------------
// ftsr_out_if
// Result channel of the regulator: duty and speed of each fan.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftsr_out_if
  import ftsr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty_fan0;
  logic [DUTY_W-1:0]  duty_fan1;
  logic [DUTY_W-1:0]  duty_fan2;
  logic [DUTY_W-1:0]  duty_fan3;
  logic [SPEED_W-1:0] speed_fan0;
  logic [SPEED_W-1:0] speed_fan1;
  logic [SPEED_W-1:0] speed_fan2;
  logic [SPEED_W-1:0] speed_fan3;

  modport source (
    output valid, duty_fan0, duty_fan1, duty_fan2, duty_fan3,
           speed_fan0, speed_fan1, speed_fan2, speed_fan3,
    input  ready
  );

  modport sink (
    input  valid, duty_fan0, duty_fan1, duty_fan2, duty_fan3,
           speed_fan0, speed_fan1, speed_fan2, speed_fan3,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/ftsr_cfg_if.sv
// ----------------------------------------------------------------------------
// ftsr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftsr_cfg_if
  import ftsr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/ftsr_ctrl.sv
// ----------------------------------------------------------------------------
// ftsr_ctrl
// Controller: sequences one request through execute, the per-fan
// regulation pass (regulating ticks only) and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsr_ctrl
  import ftsr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       out_ready,
  output logic            out_valid,
  input  wire dp_status_t sts,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.fan_clr = 1'b1;
        state_nxt   = sts.regulate ? ST_ERR : ST_DONE;
      end
      ST_ERR: begin
        cmd.err_en = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr_en = 1'b1;
        state_nxt  = ST_STEP;
      end
      ST_STEP: begin
        cmd.step_en = 1'b1;
        state_nxt   = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply_en = 1'b1;
        state_nxt    = sts.last_fan ? ST_DONE : ST_ERR;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/ftsr_datapath.sv
// ----------------------------------------------------------------------------
// ftsr_datapath
// Datapath: config registers, tach debounce and edge counters, speed
// deltas, the shared regulation unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsr_datapath
  import ftsr_pkg::*;
#(
  parameter int FAN_COUNT    = 4,
  parameter int HISTORY_BITS = 8,
  parameter int COUNT_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 sts,
  // request fields
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [TACH_W-1:0]     in_tach_bits,
  input  wire logic [SLOT_W-1:0]     in_sample_slot,
  input  wire logic [FIDX_W-1:0]     in_fan_index,
  input  wire logic [RPM_BITS-1:0]   in_target_value,
  // config writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // result
  output logic [DUTY_W-1:0]          duty_q  [OUT_FANS],
  output logic [SPEED_W-1:0]         speed_q [OUT_FANS]
);

  localparam int FAN_W  = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;
  localparam int HIDX_W = $clog2(HISTORY_BITS);
  localparam int RPM_W  = COUNT_BITS + 4;
  localparam int ERR_W  = (RPM_W > RPM_BITS) ? RPM_W : RPM_BITS;
  localparam int PROD_W = 24;

  // config registers
  logic [7:0]          duty_step_r;
  logic [31:0]         init_duties_r;
  logic [7:0]          fan_modes_r;
  logic [31:0]         fixed_duties_r;
  logic [RPM_BITS-1:0] target_r [OUT_FANS];

  // latched request
  cmd_t                cmd_r;
  logic [TACH_W-1:0]   tach_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [FIDX_W-1:0]   fidx_r;
  logic [RPM_BITS-1:0] tval_r;

  // per-fan state
  logic [HISTORY_BITS-1:0] hist_r  [FAN_COUNT];
  logic                    level_r [FAN_COUNT];
  logic [COUNT_BITS-1:0]   edge_r  [FAN_COUNT];
  logic [COUNT_BITS-1:0]   prev_r  [FAN_COUNT];
  logic [COUNT_BITS-1:0]   delta_r [FAN_COUNT];
  logic [DUTY_W-1:0]       duty_r  [FAN_COUNT];
  logic [RPM_BITS-1:0]     dyn_r   [FAN_COUNT];
  logic [1:0]              phase_r;

  // regulation unit
  logic [FAN_W-1:0] fan_r;
  logic [ERR_W-1:0] err_r;
  logic             slow_r;
  logic             mode_ok_r;
  logic             act_r;
  logic             big_r;
  logic [3:0]       d_r;
  logic [7:0]       dsq_r;
  logic [8:0]       step_r;

  // per-fan views of the config words
  logic [1:0]          mode_a [FAN_COUNT];
  logic [DUTY_W-1:0]   init_a [FAN_COUNT];
  logic [DUTY_W-1:0]   fix_a  [FAN_COUNT];
  logic [RPM_BITS-1:0] tgt_a  [FAN_COUNT];
  logic [DUTY_W-1:0]   rst_duty_a [FAN_COUNT];

  for (genvar g = 0; g < FAN_COUNT; g++) begin : g_fan_cfg
    if (g < OUT_FANS) begin : g_real
      assign mode_a[g]     = fan_modes_r[2*g +: 2];
      assign init_a[g]     = init_duties_r[8*g +: 8];
      assign fix_a[g]      = fixed_duties_r[8*g +: 8];
      assign tgt_a[g]      = target_r[g];
      assign rst_duty_a[g] = INITIAL_DUTIES_RST[8*g +: 8];
    end else begin : g_none
      assign mode_a[g]     = MODE_STATIC;
      assign init_a[g]     = '0;
      assign fix_a[g]      = '0;
      assign tgt_a[g]      = '0;
      assign rst_duty_a[g] = '0;
    end
  end

  // sample slot folded into the history length
  logic [4:0]          slot_fold;
  logic [HIDX_W-1:0]   slot_idx;
  logic [MAX_FANS-1:0] tach_ext;
  logic [HISTORY_BITS-1:0] hist_nxt [FAN_COUNT];
  logic                    level_nxt [FAN_COUNT];
  logic                    rise [FAN_COUNT];

  always_comb begin
    slot_fold = {2'b00, slot_r};
    for (int k = 0; k < 3; k++) begin
      if (slot_fold >= 5'(HISTORY_BITS)) begin
        slot_fold = slot_fold - 5'(HISTORY_BITS);
      end
    end
    slot_idx = slot_fold[HIDX_W-1:0];
    tach_ext = MAX_FANS'(tach_r);
    for (int f = 0; f < FAN_COUNT; f++) begin
      hist_nxt[f]           = hist_r[f];
      hist_nxt[f][slot_idx] = tach_ext[f];
      if (&hist_nxt[f]) begin
        level_nxt[f] = 1'b1;
      end else if (~|hist_nxt[f]) begin
        level_nxt[f] = 1'b0;
      end else begin
        level_nxt[f] = level_r[f];
      end
      rise[f] = level_nxt[f] && !level_r[f];
    end
  end

  logic [1:0] phase_nxt;
  assign phase_nxt = phase_r + 2'd1;

  assign sts.regulate = (cmd_r == CMD_TICK) && (phase_r == PHASE_PRE_REG);
  assign sts.last_fan = (fan_r == FAN_W'(FAN_COUNT - 1));

  // selected fan for the regulation pass
  logic [1:0]            mode_sel;
  logic [RPM_BITS-1:0]   tgt_sel;
  logic [COUNT_BITS-1:0] delta_sel;
  logic [RPM_W-1:0]      rpm_sel;
  logic [ERR_W-1:0]      rpm_e;
  logic [ERR_W-1:0]      tgt_e;
  logic [PROD_W-1:0]     div_prod;
  logic [15:0]           step_prod;
  logic [DUTY_W-1:0]     duty_cur;
  logic [9:0]            duty_sum;

  always_comb begin
    mode_sel  = mode_a[fan_r];
    tgt_sel   = (mode_sel == MODE_DYNAMIC) ? dyn_r[fan_r] : tgt_a[fan_r];
    delta_sel = delta_r[fan_r];
    rpm_sel   = (RPM_W'(delta_sel) << 4) - RPM_W'(delta_sel);
    rpm_e     = ERR_W'(rpm_sel);
    tgt_e     = ERR_W'(tgt_sel);
    div_prod  = PROD_W'(err_r[10:0]) * PROD_W'(DIV100_MUL);
    step_prod = 16'(duty_step_r) * 16'(dsq_r);
    duty_cur  = duty_r[fan_r];
    duty_sum  = 10'(duty_cur) + 10'(step_r);
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_step_r    <= DUTY_STEP_RST;
      init_duties_r  <= INITIAL_DUTIES_RST;
      fan_modes_r    <= FAN_MODES_RST;
      fixed_duties_r <= FIXED_DUTIES_RST;
      for (int i = 0; i < OUT_FANS; i++) begin
        target_r[i] <= TARGET_RST[i];
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_DUTY_STEP:      duty_step_r    <= cfg_data[7:0];
        REG_INITIAL_DUTIES: init_duties_r  <= cfg_data;
        REG_FAN_MODES:      fan_modes_r    <= cfg_data[7:0];
        REG_FIXED_DUTIES:   fixed_duties_r <= cfg_data;
        REG_TARGET_FAN0:    target_r[0]    <= cfg_data[RPM_BITS-1:0];
        REG_TARGET_FAN1:    target_r[1]    <= cfg_data[RPM_BITS-1:0];
        REG_TARGET_FAN2:    target_r[2]    <= cfg_data[RPM_BITS-1:0];
        REG_TARGET_FAN3:    target_r[3]    <= cfg_data[RPM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r  <= cmd_t'(in_command);
      tach_r <= in_tach_bits;
      slot_r <= in_sample_slot;
      fidx_r <= in_fan_index;
      tval_r <= in_target_value;
    end
  end

  // per-fan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      fan_r   <= '0;
      for (int f = 0; f < FAN_COUNT; f++) begin
        hist_r[f]  <= '0;
        level_r[f] <= 1'b0;
        edge_r[f]  <= '0;
        prev_r[f]  <= '0;
        delta_r[f] <= '0;
        dyn_r[f]   <= '0;
        duty_r[f]  <= rst_duty_a[f];
      end
    end else begin
      if (cmd.exec) begin
        case (cmd_r)
          CMD_TACH: begin
            for (int f = 0; f < FAN_COUNT; f++) begin
              hist_r[f]  <= hist_nxt[f];
              level_r[f] <= level_nxt[f];
              if (rise[f]) begin
                edge_r[f] <= edge_r[f] + 1'b1;
              end
            end
          end
          CMD_TICK: begin
            phase_r <= phase_nxt;
            if (phase_nxt[0]) begin
              for (int f = 0; f < FAN_COUNT; f++) begin
                delta_r[f] <= edge_r[f] - prev_r[f];
                prev_r[f]  <= edge_r[f];
              end
            end
          end
          CMD_SET_TARGET: begin
            for (int f = 0; f < FAN_COUNT; f++) begin
              if (4'(fidx_r) == 4'(f)) begin
                dyn_r[f] <= tval_r;
              end
            end
          end
          CMD_RESTORE: begin
            for (int f = 0; f < FAN_COUNT; f++) begin
              duty_r[f] <= init_a[f];
            end
          end
          default: begin
          end
        endcase
      end

      if (cmd.fan_clr) begin
        fan_r <= '0;
      end else if (cmd.apply_en && !sts.last_fan) begin
        fan_r <= fan_r + 1'b1;
      end

      if (cmd.apply_en && act_r) begin
        if (slow_r) begin
          if (step_r >= 9'(duty_cur)) begin
            duty_r[fan_r] <= '0;
          end else begin
            duty_r[fan_r] <= duty_cur - step_r[7:0];
          end
        end else begin
          duty_r[fan_r] <= (duty_sum > 10'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : duty_sum[7:0];
        end
      end
    end
  end

  // regulation unit: error, error / 100, d*d + 1, step, one stage each
  always_ff @(posedge clk) begin
    if (cmd.err_en) begin
      slow_r    <= rpm_e < tgt_e;
      err_r     <= (rpm_e < tgt_e) ? (tgt_e - rpm_e) : (rpm_e - tgt_e);
      mode_ok_r <= mode_sel <= MODE_DYNAMIC;
    end
    if (cmd.div_en) begin
      act_r <= mode_ok_r && (err_r > ERR_W'(DEADBAND));
      big_r <= err_r >= ERR_W'(ERR_SAT_LIM);
      d_r   <= div_prod[DIV100_SH +: 4];
    end
    if (cmd.sqr_en) begin
      dsq_r <= 8'({4'd0, d_r} * {4'd0, d_r}) + 8'd1;
    end
    if (cmd.step_en) begin
      // anything past 255 behaves the same against an 8-bit duty
      if ((big_r && (duty_step_r != 8'd0)) || (step_prod > 16'd255)) begin
        step_r <= 9'd256;
      end else begin
        step_r <= step_prod[8:0];
      end
    end
  end

  // output register
  for (genvar g = 0; g < OUT_FANS; g++) begin : g_out
    logic [DUTY_W-1:0]  duty_o;
    logic [SPEED_W-1:0] speed_o;
    if (g < FAN_COUNT) begin : g_real
      logic [RPM_W-1:0] rpm_o;
      assign rpm_o   = (RPM_W'(delta_r[g]) << 4) - RPM_W'(delta_r[g]);
      assign speed_o = SPEED_W'(rpm_o);
      assign duty_o  = (mode_a[g] > MODE_DYNAMIC) ? fix_a[g] : duty_r[g];
    end else begin : g_none
      assign speed_o = '0;
      assign duty_o  = '0;
    end

    always_ff @(posedge clk) begin
      if (cmd.out_load) begin
        duty_q[g]  <= duty_o;
        speed_q[g] <= speed_o;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/fan_tach_speed_regulator_core.sv
// ----------------------------------------------------------------------------
// fan_tach_speed_regulator_core
// Four-fan speed regulator: tach debounce and edge counting, per-second
// speed deltas and deadband duty regulation.
// ----------------------------------------------------------------------------
//
//   channel  dir   handshake      carries
//   in_if    in    valid/ready    command, tach_bits, sample_slot,
//                                 fan_index, target_value
//   out_if   out   valid/ready    duty_fan0..3, speed_fan0..3
//   cfg_if   in    valid/ready    index, data (ready held high)
//
// tach sample, dynamic target, power restore and non-regulating ticks go
// from request straight through execute to the result register.
// every fourth tick regulates before the result: the fans go one after
// another through the shared error, divide, square and step unit.
// rst_n is synchronous; it restores config defaults and initial duties.
// a finished result sits in the output register; the next request is taken
// meanwhile and its result waits in the datapath until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_tach_speed_regulator_core
  import ftsr_pkg::*;
#(
  parameter int FAN_COUNT    = 4,
  parameter int HISTORY_BITS = 8,
  parameter int COUNT_BITS   = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ftsr_in_if.sink     in_if,
  ftsr_out_if.source  out_if,
  ftsr_cfg_if.sink    cfg_if
);

  ctrl_cmd_t          cmd;
  dp_status_t         sts;
  logic [DUTY_W-1:0]  duty_q  [OUT_FANS];
  logic [SPEED_W-1:0] speed_q [OUT_FANS];

  assign cfg_if.ready = 1'b1;

  ftsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  ftsr_datapath #(
    .FAN_COUNT    (FAN_COUNT),
    .HISTORY_BITS (HISTORY_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_if.command),
    .in_tach_bits    (in_if.tach_bits),
    .in_sample_slot  (in_if.sample_slot),
    .in_fan_index    (in_if.fan_index),
    .in_target_value (in_if.target_value),
    .cfg_we          (cfg_if.valid),
    .cfg_idx         (cfg_if.index),
    .cfg_data        (cfg_if.data),
    .duty_q          (duty_q),
    .speed_q         (speed_q)
  );

  assign out_if.duty_fan0  = duty_q[0];
  assign out_if.duty_fan1  = duty_q[1];
  assign out_if.duty_fan2  = duty_q[2];
  assign out_if.duty_fan3  = duty_q[3];
  assign out_if.speed_fan0 = speed_q[0];
  assign out_if.speed_fan1 = speed_q[1];
  assign out_if.speed_fan2 = speed_q[2];
  assign out_if.speed_fan3 = speed_q[3];

endmodule

`default_nettype wire
